>>> rtl/core/multi_timer_expiry_scheduler_unit_macros.svh
// Assertion helpers for the timer scheduler top level.
`ifndef MULTI_TIMER_EXPIRY_SCHEDULER_UNIT_MACROS_SVH
`define MULTI_TIMER_EXPIRY_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define MTES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define MTES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mtes_pkg.sv
package mtes_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int CNT_W          = 5;
    localparam int TICK_W         = 64;
    localparam int PERIOD_W       = 32;
    localparam int ID_W           = 4;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 8;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SETP  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [ID_W-1:0]       id;
        logic                  id_ok;
        logic [PERIOD_W-1:0]   duration;
        logic                  immediate;
        logic                  periodic;
    } op_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] rec_cnt;
    } back_stat_t;

endpackage

>>> rtl/core/multi_timer_expiry_scheduler_unit.sv
// Bank of NUM_TIMERS one-shot or periodic timers on a 64-bit tick. Each input
// transfer advances the tick, sets a period, starts or stops a timer; then all
// armed timers due at the tick are reported in deadline order (ties to the
// lower index), one output transfer each, at most 16, the final one with tlast.
// An item with no expiry yields a single transfer with fired clear and tlast.
// Deadlines and periods sit in single-port RAMs swept one entry at a time: an
// item runs a pending pass and a final empty selection pass (after a start step
// for a start), plus a selection pass, a fire step and a write-back step for
// every timer that fires, and waits while the output is held off. A two-entry
// queue ahead of the sequencer takes new items while one is being worked on.
`include "multi_timer_expiry_scheduler_unit_macros.svh"

module multi_timer_expiry_scheduler_unit #(
    parameter int NUM_TIMERS = mtes_pkg::NUM_TIMERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // func[1:0], timer_id[5:2], duration[37:6], immediate[38], periodic[39]
    input  logic [mtes_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fired[0], fired_timer[4:1], zero[7:5]
    output logic [mtes_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);
    import mtes_pkg::*;

    logic       push;
    op_t        push_op;
    logic       q_ready;
    logic       q_valid;
    logic       pop;
    op_t        head_op;
    back_stat_t bstat;

    mtes_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_op  (push_op),
        .q_ready  (q_ready)
    );

    mtes_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .ready   (q_ready),
        .pop     (pop),
        .valid   (q_valid),
        .head_op (head_op)
    );

    mtes_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_op     (head_op),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (bstat)
    );

    // Only the final result of an item may report no expiry
    `MTES_ASSERT_IMP(a_nonlast_fired, m_tvalid && !m_tlast, m_tdata[0], "non-final result without expiry")
    // An empty result carries index zero
    `MTES_ASSERT_IMP(a_empty_zero, m_tvalid && !m_tdata[0], m_tdata[4:1] == 4'd0, "empty result with index")
    // Recorded results never exceed the per-item cap
    `MTES_ASSERT_IMP(a_cnt_cap, 1'b1, bstat.rec_cnt <= CNT_W'(MAX_RESULTS), "result count over cap")
    // Sequencer stays idle while the queue is empty
    `MTES_ASSERT_NEXT(a_idle_hold, bstat.idle && !q_valid, bstat.idle, "sequencer left idle without work")

endmodule

>>> rtl/core/mtes_ram.sv
module mtes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/mtes_front.sv
module mtes_front #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // func[1:0], timer_id[5:2], duration[37:6], immediate[38], periodic[39]
    input  logic [mtes_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             push,
    output mtes_pkg::op_t                    push_op,
    input  logic                             q_ready
);
    import mtes_pkg::*;

    // Take an item whenever the queue has room
    assign s_tready = q_ready;
    assign push     = s_tvalid && q_ready;

    // Decode the fields and flag timer ids outside the bank
    always_comb
    begin
        push_op.kind      = op_kind_t'(s_tdata[1:0]);
        push_op.id        = s_tdata[5:2];
        push_op.id_ok     = (32'(s_tdata[5:2]) < 32'(NUM_TIMERS));
        push_op.duration  = s_tdata[37:6];
        push_op.immediate = s_tdata[38];
        push_op.periodic  = s_tdata[39];
    end

endmodule

>>> rtl/core/mtes_queue.sv
module mtes_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mtes_pkg::op_t push_op,
    output logic          ready,
    input  logic          pop,
    output logic          valid,
    output mtes_pkg::op_t head_op
);
    import mtes_pkg::*;

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign ready   = (cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head_op = slot_reg[rd_reg];

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_op;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/mtes_back.sv
module mtes_back #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  mtes_pkg::op_t                     q_op,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fired[0], fired_timer[4:1], zero[7:5]
    output logic [mtes_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast,
    output mtes_pkg::back_stat_t              stat
);
    import mtes_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_PRD, S_PCHK, S_SRD, S_SCHK, S_FIRE, S_FWR, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [TICK_W-1:0]       tick_reg;
    logic [NUM_TIMERS-1:0]   armed_reg;
    logic [NUM_TIMERS-1:0]   rep_reg;
    logic [NUM_TIMERS-1:0]   pvld_reg;
    logic [NUM_TIMERS-1:0]   pend_reg;
    logic [IW-1:0]           idx_reg;
    logic [IW-1:0]           sid_reg;
    logic                    simm_reg;
    logic [IW-1:0]           best_reg;
    logic                    best_v_reg;
    logic [TICK_W-1:0]       best_dl_reg;
    logic [IW-1:0]           held_reg;
    logic                    held_v_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    out_v_reg;
    logic                    out_fired_reg;
    logic [ID_W-1:0]         out_idx_reg;
    logic                    out_last_reg;

    logic                    dl_we;
    logic [IW-1:0]           dl_addr;
    logic [TICK_W-1:0]       dl_wdata;
    logic [TICK_W-1:0]       dl_rdata;
    logic                    per_we;
    logic [IW-1:0]           per_addr;
    logic [PERIOD_W-1:0]     per_rdata;
    logic [PERIOD_W-1:0]     per_eff;
    logic [IW-1:0]           q_id;
    logic                    out_busy;
    logic                    last_idx;
    logic                    take;
    logic                    room;

    assign q_id     = IW'(q_op.id);
    assign out_busy = out_v_reg && !m_tready;
    assign last_idx = (idx_reg == IW'(NUM_TIMERS - 1));
    assign take     = pend_reg[idx_reg] && (!best_v_reg || (dl_rdata < best_dl_reg));
    assign room     = (cnt_reg < CNT_W'(MAX_RESULTS));
    assign pop      = (state_reg == S_IDLE) && q_valid;

    // A period never written reads as zero
    assign per_eff = pvld_reg[per_addr] ? per_rdata : '0;

    // Memory port control
    always_comb
    begin
        dl_we    = 1'b0;
        dl_addr  = idx_reg;
        dl_wdata = tick_reg + TICK_W'(per_eff);
        per_we   = 1'b0;
        per_addr = best_reg;
        case (state_reg)
            S_IDLE:
            begin
                per_addr = q_id;
                per_we   = q_valid && (q_op.kind == OP_SETP) && q_op.id_ok;
            end
            S_START:
            begin
                per_addr = sid_reg;
                dl_we    = 1'b1;
                dl_addr  = sid_reg;
                dl_wdata = simm_reg ? tick_reg : tick_reg + TICK_W'(per_eff);
            end
            S_FWR:
            begin
                dl_we    = rep_reg[best_reg];
                dl_addr  = best_reg;
                dl_wdata = best_dl_reg + TICK_W'(per_eff);
            end
            default:
            begin
                dl_we = 1'b0;
            end
        endcase
    end

    mtes_ram #(.WIDTH(TICK_W), .DEPTH(NUM_TIMERS)) u_deadline_ram (
        .clk   (clk),
        .we    (dl_we),
        .addr  (dl_addr),
        .wdata (dl_wdata),
        .rdata (dl_rdata)
    );

    mtes_ram #(.WIDTH(PERIOD_W), .DEPTH(NUM_TIMERS)) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .addr  (per_addr),
        .wdata (q_op.duration),
        .rdata (per_rdata)
    );

    // Sequencer: action, pending pass, then one selection pass per expiry and a final one that finds none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            armed_reg     <= '0;
            rep_reg       <= '0;
            pvld_reg      <= '0;
            pend_reg      <= '0;
            idx_reg       <= '0;
            sid_reg       <= '0;
            simm_reg      <= 1'b0;
            best_reg      <= '0;
            best_v_reg    <= 1'b0;
            best_dl_reg   <= '0;
            held_reg      <= '0;
            held_v_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_v_reg     <= 1'b0;
            out_fired_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // Drop the output once transferred
            if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        idx_reg    <= '0;
                        cnt_reg    <= '0;
                        held_v_reg <= 1'b0;
                        state_reg  <= S_PRD;
                        case (q_op.kind)
                            OP_TICK:
                            begin
                                tick_reg <= tick_reg + 1'b1;
                            end
                            OP_SETP:
                            begin
                                if (q_op.id_ok)
                                begin
                                    pvld_reg[q_id] <= 1'b1;
                                end
                            end
                            OP_START:
                            begin
                                if (q_op.id_ok)
                                begin
                                    sid_reg        <= q_id;
                                    simm_reg       <= q_op.immediate;
                                    rep_reg[q_id]  <= q_op.periodic;
                                    state_reg      <= S_START;
                                end
                            end
                            default:
                            begin
                                if (q_op.id_ok)
                                begin
                                    armed_reg[q_id] <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                S_START:
                begin
                    armed_reg[sid_reg] <= 1'b1;
                    state_reg          <= S_PRD;
                end
                S_PRD:
                begin
                    state_reg <= S_PCHK;
                end
                S_PCHK:
                begin
                    pend_reg[idx_reg] <= armed_reg[idx_reg] && (dl_rdata <= tick_reg);
                    if (last_idx)
                    begin
                        idx_reg    <= '0;
                        best_v_reg <= 1'b0;
                        state_reg  <= S_SRD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_PRD;
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SCHK;
                end
                S_SCHK:
                begin
                    if (take)
                    begin
                        best_reg    <= idx_reg;
                        best_dl_reg <= dl_rdata;
                        best_v_reg  <= 1'b1;
                    end
                    if (last_idx)
                    begin
                        state_reg <= (best_v_reg || take) ? S_FIRE : S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                end
                S_FIRE:
                begin
                    // Hold while the previous result cannot be passed on
                    if (!(room && held_v_reg && out_busy))
                    begin
                        if (room)
                        begin
                            if (held_v_reg)
                            begin
                                out_v_reg     <= 1'b1;
                                out_fired_reg <= 1'b1;
                                out_idx_reg   <= ID_W'(held_reg);
                                out_last_reg  <= 1'b0;
                            end
                            held_reg   <= best_reg;
                            held_v_reg <= 1'b1;
                            cnt_reg    <= cnt_reg + 1'b1;
                        end
                        pend_reg[best_reg] <= 1'b0;
                        if (!rep_reg[best_reg])
                        begin
                            armed_reg[best_reg] <= 1'b0;
                        end
                        state_reg <= S_FWR;
                    end
                end
                S_FWR:
                begin
                    idx_reg    <= '0;
                    best_v_reg <= 1'b0;
                    state_reg  <= S_SRD;
                end
                S_DONE:
                begin
                    if (!out_busy)
                    begin
                        out_v_reg     <= 1'b1;
                        out_fired_reg <= held_v_reg;
                        out_idx_reg   <= held_v_reg ? ID_W'(held_reg) : '0;
                        out_last_reg  <= 1'b1;
                        held_v_reg    <= 1'b0;
                        cnt_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid     = out_v_reg;
    assign m_tdata      = {3'b000, out_idx_reg, out_fired_reg};
    assign m_tlast      = out_last_reg;
    assign stat.idle    = (state_reg == S_IDLE);
    assign stat.rec_cnt = cnt_reg;

endmodule

>>> tb/sv/multi_timer_expiry_scheduler_unit_tb.sv
module multi_timer_expiry_scheduler_unit_tb;
    import mtes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = NUM_TIMERS_DEF;

    // Expected expiry reports: fired, fired_timer, last
    typedef struct packed {
        logic            fired;
        logic [ID_W-1:0] timer;
        logic            last;
    } expiry_t;

    class timer_scoreboard;
        logic [TICK_W-1:0]   tick_now;
        logic [TICK_W-1:0]   due_at [NT];
        logic [PERIOD_W-1:0] reload [NT];
        bit                  running [NT];
        bit                  repeating [NT];
        expiry_t             due_q [$];
        int                  errors;

        function new();
            tick_now = '0;
            errors   = 0;
            for (int i = 0; i < NT; i++)
            begin
                due_at[i]    = '0;
                reload[i]    = '0;
                running[i]   = 1'b0;
                repeating[i] = 1'b0;
            end
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Apply one accepted command and queue the expiries it causes
        function void note_command(input logic [IN_TDATA_W-1:0] d);
            op_kind_t        kind;
            logic [ID_W-1:0] id;
            bit              due [NT];
            int              best;
            int              count;
            expiry_t         e;
            kind = op_kind_t'(d[1:0]);
            id   = d[5:2];
            count = 0;
            case (kind)
                OP_TICK:  tick_now++;
                OP_SETP:  reload[id] = d[37:6];
                OP_START:
                begin
                    repeating[id] = d[39];
                    due_at[id]    = d[38] ? tick_now : tick_now + TICK_W'(reload[id]);
                    running[id]   = 1'b1;
                end
                default:  running[id] = 1'b0;
            endcase
            for (int i = 0; i < NT; i++)
                due[i] = running[i] && (due_at[i] <= tick_now);
            // Report in deadline order, ties to the lower index
            forever
            begin
                best = -1;
                for (int i = 0; i < NT; i++)
                    if (due[i] && (best < 0 || due_at[i] < due_at[best]))
                        best = i;
                if (best < 0)
                    break;
                due[best] = 1'b0;
                if (count < MAX_RESULTS)
                begin
                    e.fired = 1'b1;
                    e.timer = ID_W'(best);
                    e.last  = 1'b0;
                    due_q.push_back(e);
                    count++;
                end
                if (repeating[best])
                    due_at[best] += TICK_W'(reload[best]);
                else
                    running[best] = 1'b0;
            end
            if (count == 0)
            begin
                e = '{fired: 1'b0, timer: '0, last: 1'b1};
                due_q.push_back(e);
            end
            else
                due_q[$].last = 1'b1;
        endfunction

        // Compare one output transfer with the oldest expectation
        task check_expiry(input logic [OUT_TDATA_W-1:0] d, input logic last);
            expiry_t e;
            if (due_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer data=%h last=%b", d, last));
                return;
            end
            e = due_q.pop_front();
            if (d[0] !== e.fired)
                report_mismatch($sformatf("fired %b, want %b", d[0], e.fired));
            if (d[4:1] !== e.timer)
                report_mismatch($sformatf("fired_timer %0d, want %0d", d[4:1], e.timer));
            if (d[7:5] !== 3'b000)
                report_mismatch($sformatf("pad bits %b", d[7:5]));
            if (last !== e.last)
                report_mismatch($sformatf("tlast %b, want %b", last, e.last));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    timer_scoreboard sb = new();
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_cycles = 0;

    multi_timer_expiry_scheduler_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watch both sides of the block
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_command(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_expiry(m_tdata, m_tlast);
    end

    // Receiver: long hold-off on request, else random stalls (none while quiet)
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done   <= 1'b1;
            hold_cycles <= 599;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end

    function automatic logic [IN_TDATA_W-1:0] pack_cmd(input op_kind_t kind,
        input logic [ID_W-1:0] id, input logic [PERIOD_W-1:0] dur,
        input logic imm, input logic per);
        return {per, imm, dur, id, kind};
    endfunction

    // Offer one command and hold it until the transfer
    task automatic send_cmd(input logic [IN_TDATA_W-1:0] d);
        while (!quiet && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_TDATA_W'({$urandom, $urandom});
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [IN_TDATA_W-1:0] random_cmd();
        int pick;
        logic [PERIOD_W-1:0] dur;
        pick = $urandom_range(0, 99);
        dur  = ($urandom_range(0, 9) < 2) ? $urandom : $urandom_range(0, 6);
        if (pick < 40)
            return pack_cmd(OP_TICK, ID_W'($urandom), $urandom, 1'($urandom), 1'($urandom));
        else if (pick < 60)
            return pack_cmd(OP_SETP, ID_W'($urandom), dur, 1'($urandom), 1'($urandom));
        else if (pick < 83)
            return pack_cmd(OP_START, ID_W'($urandom), $urandom, 1'($urandom),
                            1'($urandom));
        else
            return pack_cmd(OP_STOP, ID_W'($urandom), $urandom, 1'($urandom), 1'($urandom));
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.due_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, zero periods, restart, idle stop
        send_cmd(pack_cmd(OP_TICK, '0, '0, 1'b0, 1'b0));
        send_cmd(pack_cmd(OP_STOP, 4'd7, '1, 1'b1, 1'b1));
        send_cmd(pack_cmd(OP_SETP, 4'd0, 32'd2, 1'b0, 1'b0));
        send_cmd(pack_cmd(OP_SETP, 4'd15, '1, 1'b1, 1'b1));
        send_cmd(pack_cmd(OP_START, 4'd15, '1, 1'b0, 1'b0));
        send_cmd(pack_cmd(OP_START, 4'd0, '0, 1'b0, 1'b1));
        send_cmd(pack_cmd(OP_START, 4'd3, '0, 1'b1, 1'b0));
        send_cmd(pack_cmd(OP_TICK, '1, '1, 1'b1, 1'b1));
        send_cmd(pack_cmd(OP_TICK, '0, '0, 1'b0, 1'b0));
        send_cmd(pack_cmd(OP_SETP, 4'd0, 32'd1, 1'b0, 1'b0));
        send_cmd(pack_cmd(OP_TICK, '0, '0, 1'b0, 1'b0));
        send_cmd(pack_cmd(OP_START, 4'd0, '0, 1'b0, 1'b1));
        send_cmd(pack_cmd(OP_STOP, 4'd0, '0, 1'b0, 1'b0));
        // Start every timer periodic and immediate; those left at period zero report on every command
        for (int i = 0; i < NT; i++)
            send_cmd(pack_cmd(OP_START, ID_W'(i), '0, 1'b1, 1'b1));
        send_cmd(pack_cmd(OP_TICK, '0, '0, 1'b0, 1'b0));
        for (int i = 0; i < NT; i++)
            send_cmd(pack_cmd(OP_STOP, ID_W'(i), '0, 1'b0, 1'b0));

        // Pause until every report is out
        wait_drained();

        // Hold the receiver off so the input queue fills and stalls
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_cmd(random_cmd());

        for (int n = 0; n < 410; n++)
        begin
            quiet = (n >= 150 && n < 230);
            send_cmd(random_cmd());
        end
        quiet = 1'b0;

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.due_q.size() != 0)
            sb.report_mismatch($sformatf("%0d reports never came", sb.due_q.size()));
        if (sb.errors == 0)
            $display("multi_timer_expiry_scheduler_unit_tb: done, clean");
        else
            $display("multi_timer_expiry_scheduler_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("multi_timer_expiry_scheduler_unit_tb: done, errors");
        $finish;
    end

endmodule

>>> multi_timer_expiry_scheduler_unit.f
+incdir+rtl/core
rtl/core/mtes_pkg.sv
rtl/core/mtes_ram.sv
rtl/core/mtes_front.sv
rtl/core/mtes_queue.sv
rtl/core/mtes_back.sv
rtl/core/multi_timer_expiry_scheduler_unit.sv
tb/sv/multi_timer_expiry_scheduler_unit_tb.sv
